[hw/rtl/szvd_pkg.sv]
// Shared types and constants of the zigzag varint record decoder.
`timescale 1ns / 1ps

package szvd_pkg;

   // Byte codes and bit positions of the encoded stream.
   localparam logic [7:0] MARKER_BYTE  = 8'hFF;
   localparam int         CONT_BIT     = 7;
   localparam int         LONG_BIT     = 1;
   localparam int         PAYLOAD_W    = 7;

   // Varint group bookkeeping: group 9 keeps one bit, group 10 saturates.
   localparam logic [3:0] GROUP_TOP    = 4'd9;
   localparam logic [3:0] GROUP_SAT    = 4'd10;

   // Record counter range.
   localparam logic [15:0] RECORD_FIRST = 16'd1;
   localparam logic [15:0] RECORD_LAST  = 16'hFFFF;

   // Result kind codes.
   localparam logic KIND_FIELD = 1'b0;
   localparam logic KIND_END   = 1'b1;

   // One result beat.
   typedef struct packed {
      logic               result_kind;
      logic               field_is_long;
      logic signed [63:0] field_value;
      logic               last_field;
      logic [15:0]        record_number;
      logic               value_overflow;
   } result_type;

endpackage

[hw/rtl/szvd_parse.sv]
// Parser state and per-byte decode logic of the zigzag varint record decoder.
`timescale 1ns / 1ps

module szvd_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            data_byte,
   output logic                  result_valid,
   output szvd_pkg::result_type  result
);

   typedef enum logic [1:0] {
      PHASE_MARKER = 2'd0,
      PHASE_KEY    = 2'd1,
      PHASE_VARINT = 2'd2,
      PHASE_HALTED = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  group_ff, group_in;
   logic        is_long_ff, is_long_in;
   logic        more_ff, more_in;
   logic [15:0] record_ff, record_in;
   logic        ovf_ff, ovf_in;

   logic [szvd_pkg::PAYLOAD_W-1:0] payload;
   logic [5:0]  shamt;
   logic [63:0] contrib;
   logic        ovf_hit;

   // State registers advance only when a byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_MARKER;
         acc_ff     <= '0;
         group_ff   <= '0;
         is_long_ff <= 1'b0;
         more_ff    <= 1'b0;
         record_ff  <= szvd_pkg::RECORD_FIRST;
         ovf_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         group_ff   <= group_in;
         is_long_ff <= is_long_in;
         more_ff    <= more_in;
         record_ff  <= record_in;
         ovf_ff     <= ovf_in;
      end
   end

   // Contribution of the current varint group to the accumulator.
   always_comb begin
      payload = data_byte[szvd_pkg::PAYLOAD_W-1:0];
      shamt   = {2'b00, group_ff} * 6'd7;
      contrib = '0;
      ovf_hit = 1'b0;
      if (group_ff < szvd_pkg::GROUP_TOP) begin
         contrib = {57'd0, payload} << shamt;
      end else if (group_ff == szvd_pkg::GROUP_TOP) begin
         contrib = {payload[0], 63'd0};
         ovf_hit = |payload[szvd_pkg::PAYLOAD_W-1:1];
      end else begin
         ovf_hit = |payload;
      end
   end

   // Next state and result of the byte at hand.
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      group_in     = group_ff;
      is_long_in   = is_long_ff;
      more_in      = more_ff;
      record_in    = record_ff;
      ovf_in       = ovf_ff;
      result_valid = 1'b0;
      result       = '0;

      case (phase_ff)
         PHASE_MARKER: begin
            if (data_byte == szvd_pkg::MARKER_BYTE) begin
               phase_in = PHASE_KEY;
            end else begin
               phase_in             = PHASE_HALTED;
               result_valid         = 1'b1;
               result.result_kind   = szvd_pkg::KIND_END;
               result.record_number = record_ff;
            end
         end
         PHASE_KEY: begin
            is_long_in = data_byte[szvd_pkg::LONG_BIT];
            more_in    = data_byte[szvd_pkg::CONT_BIT];
            acc_in     = '0;
            group_in   = '0;
            ovf_in     = 1'b0;
            phase_in   = PHASE_VARINT;
         end
         PHASE_VARINT: begin
            acc_in = acc_ff | contrib;
            ovf_in = ovf_ff | ovf_hit;
            if (group_ff < szvd_pkg::GROUP_SAT) begin
               group_in = group_ff + 4'd1;
            end
            // A byte without the continuation bit closes the field.
            if (!data_byte[szvd_pkg::CONT_BIT]) begin
               result_valid          = 1'b1;
               result.result_kind    = szvd_pkg::KIND_FIELD;
               result.field_is_long  = is_long_ff;
               result.field_value    = (acc_in >> 1) ^ {64{acc_in[0]}};
               result.last_field     = !more_ff;
               result.record_number  = record_ff;
               result.value_overflow = ovf_in;
               if (more_ff) begin
                  phase_in = PHASE_KEY;
               end else begin
                  phase_in  = PHASE_MARKER;
                  record_in = (record_ff == szvd_pkg::RECORD_LAST) ?
                              szvd_pkg::RECORD_FIRST : record_ff + 16'd1;
               end
            end
         end
         default: begin
            // Halted: bytes are consumed and ignored.
            phase_in = PHASE_HALTED;
         end
      endcase
   end

endmodule

[hw/rtl/szvd_out_reg.sv]
// Result register of the zigzag varint record decoder.
`timescale 1ns / 1ps

module szvd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  szvd_pkg::result_type  load_data,
   input  logic                  rsp_stall,
   output logic                  free,
   output logic                  rsp_valid,
   output szvd_pkg::result_type  rsp_data
);

   logic                 valid_ff, valid_in;
   szvd_pkg::result_type data_ff;

   // The register can take a new beat when empty or drained this cycle.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   // Valid is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[hw/rtl/struct_zigzag_varint_decoder_top.sv]
// Top level of the zigzag varint record decoder.
// Takes one byte of the encoded stream per beat and, with no stall on the result side,
// sustains one byte per clock cycle. An accepted byte is held in the input register while
// the parser decodes it, and its result beat (if any) is loaded into the result register
// once that register can take it, and is offered to the receiver from there. The rate is set
// by the parser's state update; a stalled, full result register holds the input register and
// so stalls the input. Each record opens with an 0xFF marker; one result beat is given per
// completed field, and a non-marker byte where a marker is due gives one end-of-data beat,
// after which every byte is taken and ignored until reset.
`timescale 1ns / 1ps

module struct_zigzag_varint_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic               rsp_field_is_long,
   output logic signed [63:0] rsp_field_value,
   output logic               rsp_last_field,
   output logic [15:0]        rsp_record_number,
   output logic               rsp_value_overflow
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_free;
   logic                 advance;
   logic                 parse_valid;
   szvd_pkg::result_type parse_result;
   szvd_pkg::result_type out_data;

   // The held byte is decoded once the result register can take its beat.
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Parser.
   szvd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .data_byte    (in_byte_ff),
      .result_valid (parse_valid),
      .result       (parse_result)
   );

   // Result register.
   szvd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && parse_valid),
      .load_data (parse_result),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_data)
   );

   assign rsp_result_kind    = out_data.result_kind;
   assign rsp_field_is_long  = out_data.field_is_long;
   assign rsp_field_value    = out_data.field_value;
   assign rsp_last_field     = out_data.last_field;
   assign rsp_record_number  = out_data.record_number;
   assign rsp_value_overflow = out_data.value_overflow;

`ifndef SYNTHESIS
   // An end-of-data beat carries nothing but the record number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == szvd_pkg::KIND_END) |->
      (!rsp_field_is_long && rsp_field_value == 64'sd0 && !rsp_last_field &&
       !rsp_value_overflow))
      else $error("end-of-data beat carries field data");

   // Record numbers count from one and skip zero on wrap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_record_number != 16'd0)
      else $error("record number zero on result beat");

   // The input side stalls only while a byte is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the zigzag varint record decoder.
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int STUCK_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 235;

   // Decoder position within the encoded stream.
   typedef enum logic [1:0] {
      SEEK_MARKER,
      READ_KEY,
      READ_VARINT,
      HALTED
   } parse_state_type;

   // Tracks the decoder state, predicts each field and checks the result beats.
   class field_scoreboard;
      parse_state_type      state;
      logic [63:0]          acc;
      logic [3:0]           groups;
      logic                 long_key;
      logic                 more_fields;
      logic                 lost_bits;
      logic [15:0]          record_no;
      szvd_pkg::result_type expected_fields[$];
      int                   mismatches;

      function new();
         state       = SEEK_MARKER;
         acc         = '0;
         groups      = '0;
         long_key    = 1'b0;
         more_fields = 1'b0;
         lost_bits   = 1'b0;
         record_no   = szvd_pkg::RECORD_FIRST;
         mismatches  = 0;
      endfunction

      // Advance the predicted state by one accepted byte.
      function void note_byte(input logic [7:0] b);
         logic [szvd_pkg::PAYLOAD_W-1:0] payload;
         szvd_pkg::result_type           r;
         payload = b[szvd_pkg::PAYLOAD_W-1:0];
         r = '0;
         case (state)
            SEEK_MARKER: begin
               if (b == szvd_pkg::MARKER_BYTE) begin
                  state = READ_KEY;
               end else begin
                  r.result_kind   = szvd_pkg::KIND_END;
                  r.record_number = record_no;
                  expected_fields.push_back(r);
                  state = HALTED;
               end
            end
            READ_KEY: begin
               long_key    = b[szvd_pkg::LONG_BIT];
               more_fields = b[szvd_pkg::CONT_BIT];
               acc         = '0;
               groups      = '0;
               lost_bits   = 1'b0;
               state       = READ_VARINT;
            end
            READ_VARINT: begin
               // Group nine keeps only its low bit; later groups are dropped.
               if (groups < szvd_pkg::GROUP_TOP) begin
                  acc = acc | (64'(payload) << (szvd_pkg::PAYLOAD_W * groups));
               end else if (groups == szvd_pkg::GROUP_TOP) begin
                  acc[63] = acc[63] | payload[0];
                  if (payload[szvd_pkg::PAYLOAD_W-1:1] != '0) lost_bits = 1'b1;
               end else if (payload != '0) begin
                  lost_bits = 1'b1;
               end
               if (groups < szvd_pkg::GROUP_SAT) groups = groups + 4'd1;
               if (!b[szvd_pkg::CONT_BIT]) begin
                  r.result_kind    = szvd_pkg::KIND_FIELD;
                  r.field_is_long  = long_key;
                  r.field_value    = (acc >> 1) ^ {64{acc[0]}};
                  r.last_field     = !more_fields;
                  r.record_number  = record_no;
                  r.value_overflow = lost_bits;
                  expected_fields.push_back(r);
                  if (more_fields) begin
                     state = READ_KEY;
                  end else begin
                     state = SEEK_MARKER;
                     record_no = (record_no == szvd_pkg::RECORD_LAST) ?
                                 szvd_pkg::RECORD_FIRST : record_no + 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report_mismatch(input string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one result beat with the oldest prediction.
      task check_field(input szvd_pkg::result_type got);
         szvd_pkg::result_type want;
         if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %p", got));
         end else begin
            want = expected_fields.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch($sformatf("result_kind %b, expected %b",
                                         got.result_kind, want.result_kind));
            if (got.field_is_long !== want.field_is_long)
               report_mismatch($sformatf("field_is_long %b, expected %b",
                                         got.field_is_long, want.field_is_long));
            if (got.field_value !== want.field_value)
               report_mismatch($sformatf("field_value %h, expected %h",
                                         got.field_value, want.field_value));
            if (got.last_field !== want.last_field)
               report_mismatch($sformatf("last_field %b, expected %b",
                                         got.last_field, want.last_field));
            if (got.record_number !== want.record_number)
               report_mismatch($sformatf("record_number %0d, expected %0d",
                                         got.record_number, want.record_number));
            if (got.value_overflow !== want.value_overflow)
               report_mismatch($sformatf("value_overflow %b, expected %b",
                                         got.value_overflow, want.value_overflow));
         end
      endtask

      task finish_check();
         if (expected_fields.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_fields.size()));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic               rsp_result_kind;
   logic               rsp_field_is_long;
   logic signed [63:0] rsp_field_value;
   logic               rsp_last_field;
   logic [15:0]        rsp_record_number;
   logic               rsp_value_overflow;

   logic               rsp_hold = 1'b0;
   bit                 hold_go = 1'b0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 stuck_cycles = 0;
   int                 bytes_sent = 0;
   field_scoreboard    sb = new();

   struct_zigzag_varint_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_field_is_long  (rsp_field_is_long),
      .rsp_field_value    (rsp_field_value),
      .rsp_last_field     (rsp_last_field),
      .rsp_record_number  (rsp_record_number),
      .rsp_value_overflow (rsp_value_overflow)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Offer one byte after a random gap and wait until the decoder takes it.
   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      bytes_sent = bytes_sent + 1;
   endtask

   // Extreme values, type bits, key bit zero and long varints, then a non-marker byte that ends the data.
   task send_directed();
      logic [7:0] opening[30];
      opening = '{
         8'hFF, 8'h81, 8'h00,
         8'h02, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
         8'hFF, 8'h82, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
         8'h7F, 8'h80, 8'h00,
         8'h01, 8'h01
      };
      foreach (opening[i]) send_byte(opening[i]);
   endtask

   // A well-formed record with random keys and varints of mixed length.
   task send_random_record();
      int         fields;
      int         groups;
      int         pick;
      logic [7:0] b;
      fields = $urandom_range(1, 4);
      send_byte(szvd_pkg::MARKER_BYTE);
      for (int f = 0; f < fields; f++) begin
         b = 8'($urandom_range(0, 255));
         b[szvd_pkg::CONT_BIT] = (f != fields - 1);
         send_byte(b);
         pick = $urandom_range(99);
         if (pick < 55)      groups = $urandom_range(1, 2);
         else if (pick < 85) groups = $urandom_range(3, 9);
         else                groups = $urandom_range(10, 12);
         for (int g = 0; g < groups; g++) begin
            b = 8'($urandom_range(0, 255));
            b[szvd_pkg::CONT_BIT] = (g != groups - 1);
            send_byte(b);
         end
      end
   endtask

   // Whole records until at least the given number of bytes has gone out.
   task send_random_bytes(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         send_random_record();
      end
   endtask

   // Long receiver hold-off on the result side; the decoder has halted by then and gives no more beats.
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Result side: check each accepted beat and drive the stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_field('{result_kind:    rsp_result_kind,
                          field_is_long:  rsp_field_is_long,
                          field_value:    rsp_field_value,
                          last_field:     rsp_last_field,
                          record_number:  rsp_record_number,
                          value_overflow: rsp_value_overflow});
      end
      rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // Main sequence.
   initial begin
      logic [7:0] b;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_directed();

      // Sender mostly busy, receiver mostly stalled.
      send_idle_pct = 19;
      recv_idle_pct = 85;
      send_random_bytes(PHASE_BYTES);

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct = 85;
      recv_idle_pct = 19;
      send_random_bytes(PHASE_BYTES);

      // Full rate on both sides, with one long receiver hold-off.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go = 1'b1;
      send_random_bytes(PHASE_BYTES);

      // A further non-marker byte and later bytes; the data has already ended, so all are ignored.
      b = 8'($urandom_range(0, 254));
      send_byte(b);
      repeat (6) send_byte(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      while (sb.expected_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.finish_check();
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
